// ----- design/modexp_pkg.sv -----
// Shared types and constants for the modular exponentiation core.
package modexp_pkg;

	localparam int OPERAND_WIDTH = 32;

	typedef logic [OPERAND_WIDTH-1:0] operand_t;

	typedef struct packed {
		operand_t base;
		operand_t exponent;
		operand_t modulus;
	} req_t;

	typedef struct packed {
		operand_t result;
		logic     error;
	} rsp_t;

endpackage

// ----- design/modular_exponentiation.sv -----
// Modular exponentiation (base ** exponent mod modulus) on one shared add-mod unit.
//
// Two valid/ready channels. The request word carries base, exponent and modulus;
// the response word carries result and error. One request is in flight at a time:
// req_ready is high only while the core is idle, so the next request is taken in
// the cycle after the response is taken.
// A zero modulus answers error = 1, result = 0 in the cycle after acceptance; a zero
// exponent answers result = 1 likewise. Otherwise the base is first reduced by
// restoring shift-subtract over all W base bits (W = operand width), then
// left-to-right square-and-multiply runs over all W exponent bits. Each modular
// product is built by doubling over the multiplier bits, top bit first, with an
// extra add for each set bit, all on the single (x + y + c) mod m adder/comparator,
// which sets the rate. The response is held in an output register until rsp_ready;
// nothing else moves while it waits. Reset (arst_n low) returns the core to idle
// with no response pending; no state is kept between requests.
module modular_exponentiation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  modexp_pkg::req_t   req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output modexp_pkg::rsp_t   rsp
);

	localparam int W     = modexp_pkg::OPERAND_WIDTH;
	localparam int IDX_W = $clog2(W);
	localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_SQ,
		ST_MUL,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [W-1:0]       base_q;
	logic [W-1:0]       exp_q;
	logic [W-1:0]       mod_q;
	logic [W-1:0]       red_q;
	logic [W-1:0]       acc_q;
	logic [W-1:0]       prod_q;
	logic [IDX_W-1:0]   rcnt_q;
	logic [IDX_W-1:0]   ebit_q;
	logic [IDX_W-1:0]   mbit_q;
	logic               add_ph_q;
	modexp_pkg::rsp_t   rsp_q;

	// shared unit: (x + y + c) mod m, valid while x + y + c < 2m
	logic [W-1:0] u_x;
	logic [W-1:0] u_y;
	logic         u_c;
	logic [W:0]   u_sum;
	logic [W+1:0] u_diff;
	logic [W-1:0] u_out;

	logic [W-1:0] mul_a;

	assign mul_a = (state_q == ST_SQ) ? acc_q : base_q;

	always_comb begin
		u_x = prod_q;
		u_y = prod_q;
		u_c = 1'b0;
		if (state_q == ST_RED) begin
			u_x = red_q;
			u_y = red_q;
			u_c = base_q[rcnt_q];
		end else if (add_ph_q) begin
			u_y = mul_a;
		end
	end

	assign u_sum  = {1'b0, u_x} + {1'b0, u_y} + {{W{1'b0}}, u_c};
	assign u_diff = {1'b0, u_sum} - {2'b00, mod_q};
	assign u_out  = u_diff[W+1] ? u_sum[W-1:0] : u_diff[W-1:0];

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = (state_q == ST_DONE);
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			add_ph_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						base_q   <= req.base;
						exp_q    <= req.exponent;
						mod_q    <= req.modulus;
						red_q    <= '0;
						rcnt_q   <= IDX_TOP;
						add_ph_q <= 1'b0;
						if (req.modulus == '0) begin
							rsp_q   <= '{result: '0, error: 1'b1};
							state_q <= ST_DONE;
						end else if (req.exponent == '0) begin
							rsp_q   <= '{result: W'(1), error: 1'b0};
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RED;
						end
					end
				end
				ST_RED: begin
					red_q  <= u_out;
					rcnt_q <= rcnt_q - IDX_W'(1);
					if (rcnt_q == '0) begin
						base_q   <= u_out;
						acc_q    <= (mod_q == W'(1)) ? '0 : W'(1);
						prod_q   <= '0;
						ebit_q   <= IDX_TOP;
						mbit_q   <= IDX_TOP;
						add_ph_q <= 1'b0;
						state_q  <= ST_SQ;
					end
				end
				ST_SQ, ST_MUL: begin
					prod_q <= u_out;
					if (!add_ph_q && acc_q[mbit_q]) begin
						add_ph_q <= 1'b1;
					end else begin
						add_ph_q <= 1'b0;
						mbit_q   <= mbit_q - IDX_W'(1);
						if (mbit_q == '0) begin
							// product complete
							acc_q  <= u_out;
							prod_q <= '0;
							mbit_q <= IDX_TOP;
							if (state_q == ST_SQ && exp_q[ebit_q]) begin
								state_q <= ST_MUL;
							end else if (ebit_q == '0) begin
								rsp_q   <= '{result: u_out, error: 1'b0};
								state_q <= ST_DONE;
							end else begin
								ebit_q  <= ebit_q - IDX_W'(1);
								state_q <= ST_SQ;
							end
						end
					end
				end
				ST_DONE: begin
					if (rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("request taken while a response is pending");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.error) |-> (rsp.result == '0))
		else $error("error response with nonzero result");

	a_red_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RED) |-> (red_q < mod_q))
		else $error("partial remainder not below modulus");

	a_mul_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ || state_q == ST_MUL) |->
			(acc_q < mod_q && prod_q < mod_q && base_q < mod_q))
		else $error("operand out of residue range");

	a_mul_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && $past(state_q) == ST_SQ) |-> (prod_q == '0 && !add_ph_q))
		else $error("multiply entered with stale partial product");

endmodule
